FILE: sv/eid_pkg.sv
package eid_pkg;

  localparam logic [7:0] PFX_MOVI = 8'h8A;
  localparam logic [7:0] PFX_EXT  = 8'h8E;

  // Group codes held in bits 15..12 of the second word under the extended prefix.
  localparam logic [3:0] GRP_IDX    = 4'h0;
  localparam logic [3:0] GRP_STL    = 4'h1;
  localparam logic [3:0] GRP_ST     = 4'h2;
  localparam logic [3:0] GRP_LDL    = 4'h5;
  localparam logic [3:0] GRP_LD     = 4'h6;
  localparam logic [3:0] GRP_ADD    = 4'h7;
  localparam logic [3:0] GRP_MOVA   = 4'h9;
  localparam logic [3:0] GRP_BRA    = 4'hA;
  localparam logic [3:0] GRP_BSR    = 4'hB;
  localparam logic [3:0] GRP_MOV    = 4'hE;

  localparam logic [15:0] ALL_ONES16 = 16'hFFFF;
  localparam logic [31:0] ALIGN_MASK = ~32'd3;

  typedef enum logic [3:0] {
    OP_MOVB  = 4'd0,
    OP_MOVW  = 4'd1,
    OP_MOVL  = 4'd2,
    OP_FMOVS = 4'd3,
    OP_LEAB  = 4'd4,
    OP_LEAW  = 4'd5,
    OP_LEAL  = 4'd6,
    OP_LEAQ  = 4'd7,
    OP_MOVUB = 4'd8,
    OP_MOVUW = 4'd9,
    OP_MOVUL = 4'd10,
    OP_ADD   = 4'd11,
    OP_MOV   = 4'd12,
    OP_MOVA  = 4'd13,
    OP_BRA   = 4'd14,
    OP_BSR   = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    FORM_ST_IDX  = 3'd0,
    FORM_LD_IDX  = 3'd1,
    FORM_ST_DISP = 3'd2,
    FORM_LD_DISP = 3'd3,
    FORM_REG_IMM = 3'd4,
    FORM_LD_ABS  = 3'd5,
    FORM_ABS     = 3'd6
  } form_t;

  typedef struct packed {
    logic        recognized;
    op_t         operation;
    form_t       addr_form;
    logic [3:0]  dest_reg;
    logic [3:0]  src_reg;
    logic        src_is_pc;
    logic [15:0] index_field;
    logic [31:0] immediate;
    logic        control_flow;
    logic        delay_slot;
    logic        invalid_in_delay_slot;
    logic        pc_relative_delay;
  } dec_t;

  function automatic dec_t make_dec(input op_t op, input form_t form, input logic [3:0] rn,
                                    input logic [3:0] rm, input logic [15:0] ro,
                                    input logic [31:0] imm);
    dec_t d;
    d             = '0;
    d.recognized  = 1'b1;
    d.operation   = op;
    d.addr_form   = form;
    d.dest_reg    = rn;
    d.src_reg     = rm;
    d.index_field = ro;
    d.immediate   = imm;
    return d;
  endfunction

  function automatic dec_t decode_instr(input logic [15:0] fw, input logic [15:0] sw,
                                        input logic [31:0] pc);
    dec_t        d;
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [3:0]  rn;
    logic [3:0]  rm;
    logic [3:0]  nib_ro;
    logic [1:0]  sh;
    logic [31:0] nib32;
    logic [31:0] d8;
    logic [15:0] w16;
    logic [31:0] w16s;
    logic [31:0] d20;
    d      = '0;
    hi     = sw[15:12];
    lo     = sw[3:0];
    rn     = sw[11:8];
    rm     = sw[7:4];
    nib_ro = fw[7:4];
    // Most scaled forms shift by the low two bits of the sub-opcode; the STL, LDL and FMOVS forms shift by a fixed two.
    sh     = lo[1:0];
    nib32  = {28'd0, fw[3:0]};
    d8     = {{24{fw[7]}}, fw[7:0]};
    w16    = {sw[7:0], fw[7:0]} & ALL_ONES16;
    w16s   = {{16{w16[15]}}, w16};
    d20    = {{12{sw[11]}}, sw[11:0], fw[7:0]};

    unique case (fw[15:8])
      PFX_MOVI: begin
        d = make_dec(OP_MOV, FORM_REG_IMM, 4'd0, 4'd0, 16'd0, {d8[15:0], sw});
      end
      PFX_EXT: begin
        unique case (hi) inside
          GRP_IDX: begin
            if (lo >= 4'd4 && lo <= 4'd6) begin
              d = make_dec(op_t'(lo - 4'd4), FORM_ST_IDX, rn, rm, {12'd0, nib_ro}, nib32 << sh);
            end else if (lo >= 4'd12 && lo <= 4'd14) begin
              d = make_dec(op_t'(lo - 4'd12), FORM_LD_IDX, rn, rm, {12'd0, nib_ro},
                           nib32 << sh);
            end
          end
          GRP_STL: begin
            d = make_dec(OP_MOVL, FORM_ST_IDX, rn, rm, {12'd0, lo}, d8 << 2);
          end
          GRP_ST: begin
            if (lo <= 4'd2) begin
              d = make_dec(op_t'(lo), FORM_ST_DISP, rn, rm, 16'd0, d8 << sh);
            end else if (lo == 4'd4) begin
              d = make_dec(OP_FMOVS, FORM_LD_DISP, rn, rm, 16'd0, d8 << 2);
            end else if (lo == 4'd6) begin
              d = make_dec(OP_FMOVS, FORM_ST_DISP, rn, rm, 16'd0, d8 << 2);
            end
          end
          GRP_LDL: begin
            d = make_dec(OP_MOVL, FORM_LD_IDX, rn, rm, {12'd0, lo}, d8 << 2);
          end
          GRP_LD: begin
            if (lo <= 4'd2) begin
              d = make_dec(op_t'(lo), FORM_LD_DISP, rn, rm, 16'd0, d8 << sh);
            end else if (lo >= 4'd4 && lo <= 4'd7) begin
              d = make_dec(op_t'(lo), FORM_LD_IDX, rn, rm, {12'd0, nib_ro}, nib32 << sh);
            end else if (lo >= 4'd8 && lo <= 4'd11) begin
              d = make_dec(op_t'(lo - 4'd4), FORM_LD_DISP, rn, rm, 16'd0, d8 << sh);
            end else if (lo >= 4'd12 && lo <= 4'd14) begin
              d = make_dec(op_t'(lo - 4'd4), FORM_LD_DISP, rn, rm, 16'd0, d8 << sh);
            end
          end
          GRP_ADD: begin
            d = make_dec(OP_ADD, FORM_REG_IMM, rn, 4'd0, 16'd0, w16s);
          end
          GRP_MOVA: begin
            d = make_dec(OP_MOVA, FORM_LD_ABS, rn, 4'd0, w16,
                         ((pc + 32'd6) & ALIGN_MASK) + {14'd0, w16, 2'b00});
            d.src_is_pc         = 1'b1;
            d.pc_relative_delay = 1'b1;
          end
          GRP_BRA, GRP_BSR: begin
            d = make_dec((hi == GRP_BRA) ? OP_BRA : OP_BSR, FORM_ABS, 4'd0, 4'd0, 16'd0,
                         pc + {d20[30:0], 1'b0} + 32'd6);
            d.control_flow          = 1'b1;
            d.delay_slot            = 1'b1;
            d.invalid_in_delay_slot = 1'b1;
          end
          GRP_MOV: begin
            d = make_dec(OP_MOV, FORM_REG_IMM, rn, 4'd0, 16'd0, w16s);
          end
          default: begin
            d = '0;
          end
        endcase
      end
      default: begin
        d = '0;
      end
    endcase
    return d;
  endfunction

endpackage

FILE: sv/extended_instruction_decoder.sv
// Decodes one two-word extended instruction and its address into an operation, addressing
// form, register numbers, immediate or branch target and control flags. Each item passes through
// an input register, then the decode logic, then a result register, and a new item can be
// taken every cycle while in_stall is low. in_stall rises only when both registers hold
// items and out_stall is high; encodings that decode to nothing give recognized low and
// every other field zero.
module extended_instruction_decoder
  import eid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] first_word,
  input  logic [15:0] second_word,
  input  logic [31:0] instr_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        recognized,
  output logic [3:0]  operation,
  output logic [2:0]  addr_form,
  output logic [3:0]  dest_reg,
  output logic [3:0]  src_reg,
  output logic        src_is_pc,
  output logic [15:0] index_field,
  output logic [31:0] immediate,
  output logic        control_flow,
  output logic        delay_slot,
  output logic        invalid_in_delay_slot,
  output logic        pc_relative_delay
);

  logic        s1_valid;
  logic [15:0] s1_fw;
  logic [15:0] s1_sw;
  logic [31:0] s1_pc;
  dec_t        res;
  dec_t        res_next;
  logic        out_load;
  logic        s1_load;

  assign out_load = !out_valid || !out_stall;
  assign s1_load  = !s1_valid || out_load;
  assign in_stall = !s1_load;
  assign res_next = decode_instr(s1_fw, s1_sw, s1_pc);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= in_valid;
      end
      if (out_load) begin
        out_valid <= s1_valid;
      end
    end
    if (s1_load && in_valid) begin
      s1_fw <= first_word;
      s1_sw <= second_word;
      s1_pc <= instr_address;
    end
    if (out_load && s1_valid) begin
      res <= res_next;
    end
  end

  assign recognized            = res.recognized;
  assign operation             = res.operation;
  assign addr_form             = res.addr_form;
  assign dest_reg              = res.dest_reg;
  assign src_reg               = res.src_reg;
  assign src_is_pc             = res.src_is_pc;
  assign index_field           = res.index_field;
  assign immediate             = res.immediate;
  assign control_flow          = res.control_flow;
  assign delay_slot            = res.delay_slot;
  assign invalid_in_delay_slot = res.invalid_in_delay_slot;
  assign pc_relative_delay     = res.pc_relative_delay;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while the pipeline had room");

  a_unrecognized_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !recognized) |-> (operation == 4'd0 && immediate == 32'd0 &&
                                    dest_reg == 4'd0 && index_field == 16'd0 &&
                                    control_flow == 1'b0 && src_is_pc == 1'b0))
    else $error("unrecognized item carries non-zero fields");

  a_branch_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && control_flow) |-> (delay_slot && invalid_in_delay_slot &&
                                     addr_form == FORM_ABS && recognized))
    else $error("branch item with inconsistent flags");

  a_pc_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && src_is_pc) |-> (operation == OP_MOVA && src_reg == 4'd0 &&
                                  pc_relative_delay))
    else $error("program counter source on an item other than MOVA");
`endif

endmodule

FILE: tb/eid_decode_checker.sv
`timescale 1ns / 1ps

module eid_decode_checker
  import eid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] first_word,
  input  logic [15:0] second_word,
  input  logic [31:0] instr_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        recognized,
  input  logic [3:0]  operation,
  input  logic [2:0]  addr_form,
  input  logic [3:0]  dest_reg,
  input  logic [3:0]  src_reg,
  input  logic        src_is_pc,
  input  logic [15:0] index_field,
  input  logic [31:0] immediate,
  input  logic        control_flow,
  input  logic        delay_slot,
  input  logic        invalid_in_delay_slot,
  input  logic        pc_relative_delay,
  output int          fail_count,
  output int          pending
);

  dec_t expected_decodes[$];
  int   errors = 0;

  function automatic dec_t decode_entry(input op_t op, input form_t form, input logic [3:0] rn,
                                        input logic [3:0] rm, input logic [15:0] idx,
                                        input logic [31:0] value);
    dec_t e;
    e = '0;
    e.recognized = 1'b1;
    e.operation = op;
    e.addr_form = form;
    e.dest_reg = rn;
    e.src_reg = rm;
    e.index_field = idx;
    e.immediate = value;
    return e;
  endfunction

  function automatic dec_t predict_decode(input logic [15:0] fw, input logic [15:0] sw,
                                          input logic [31:0] pc);
    dec_t        e;
    logic [3:0]  grp;
    logic [3:0]  sub;
    logic [3:0]  rn;
    logic [3:0]  rm;
    logic [15:0] nib_index;
    logic [31:0] nib;
    logic [31:0] disp8;
    logic [15:0] word16;
    logic [31:0] word16_sx;
    logic [31:0] disp20;
    e = '0;
    grp = sw[15:12];
    sub = sw[3:0];
    rn = sw[11:8];
    rm = sw[7:4];
    nib_index = {12'd0, fw[7:4]};
    nib = {28'd0, fw[3:0]};
    disp8 = {{24{fw[7]}}, fw[7:0]};
    word16 = {sw[7:0], fw[7:0]};
    word16_sx = {{16{word16[15]}}, word16};
    disp20 = {{12{sw[11]}}, sw[11:0], fw[7:0]};
    if (fw[15:8] == PFX_MOVI) begin
      // The low byte of the first word is sign-extended into the upper half.
      e = decode_entry(OP_MOV, FORM_REG_IMM, 4'd0, 4'd0, 16'd0, {disp8[15:0], sw});
    end else if (fw[15:8] == PFX_EXT) begin
      case (grp)
        GRP_IDX: begin
          if (sub >= 4'd4 && sub <= 4'd6) begin
            e = decode_entry(op_t'(sub - 4'd4), FORM_ST_IDX, rn, rm, nib_index,
                             nib << (sub - 4'd4));
          end else if (sub >= 4'd12 && sub <= 4'd14) begin
            e = decode_entry(op_t'(sub - 4'd12), FORM_LD_IDX, rn, rm, nib_index,
                             nib << (sub - 4'd12));
          end
        end
        GRP_STL: begin
          e = decode_entry(OP_MOVL, FORM_ST_IDX, rn, rm, {12'd0, sub}, disp8 << 2);
        end
        GRP_ST: begin
          if (sub <= 4'd2) begin
            e = decode_entry(op_t'(sub), FORM_ST_DISP, rn, rm, 16'd0, disp8 << sub);
          end else if (sub == 4'd4) begin
            e = decode_entry(OP_FMOVS, FORM_LD_DISP, rn, rm, 16'd0, disp8 << 2);
          end else if (sub == 4'd6) begin
            e = decode_entry(OP_FMOVS, FORM_ST_DISP, rn, rm, 16'd0, disp8 << 2);
          end
        end
        GRP_LDL: begin
          e = decode_entry(OP_MOVL, FORM_LD_IDX, rn, rm, {12'd0, sub}, disp8 << 2);
        end
        GRP_LD: begin
          if (sub <= 4'd2) begin
            e = decode_entry(op_t'(sub), FORM_LD_DISP, rn, rm, 16'd0, disp8 << sub);
          end else if (sub >= 4'd4 && sub <= 4'd7) begin
            e = decode_entry(op_t'(sub), FORM_LD_IDX, rn, rm, nib_index, nib << (sub - 4'd4));
          end else if (sub >= 4'd8 && sub <= 4'd11) begin
            e = decode_entry(op_t'(sub - 4'd4), FORM_LD_DISP, rn, rm, 16'd0,
                             disp8 << (sub - 4'd8));
          end else if (sub >= 4'd12 && sub <= 4'd14) begin
            e = decode_entry(op_t'(sub - 4'd4), FORM_LD_DISP, rn, rm, 16'd0,
                             disp8 << (sub - 4'd12));
          end
        end
        GRP_ADD: begin
          e = decode_entry(OP_ADD, FORM_REG_IMM, rn, 4'd0, 16'd0, word16_sx);
        end
        GRP_MOVA: begin
          e = decode_entry(OP_MOVA, FORM_LD_ABS, rn, 4'd0, word16,
                           ((pc + 32'd6) & ALIGN_MASK) + ({16'd0, word16} << 2));
          e.src_is_pc = 1'b1;
          e.pc_relative_delay = 1'b1;
        end
        GRP_BRA, GRP_BSR: begin
          e = decode_entry((grp == GRP_BRA) ? OP_BRA : OP_BSR, FORM_ABS, 4'd0, 4'd0, 16'd0,
                           pc + (disp20 << 1) + 32'd6);
          e.control_flow = 1'b1;
          e.delay_slot = 1'b1;
          e.invalid_in_delay_slot = 1'b1;
        end
        GRP_MOV: begin
          e = decode_entry(OP_MOV, FORM_REG_IMM, rn, 4'd0, 16'd0, word16_sx);
        end
        default: begin
          e = '0;
        end
      endcase
    end
    return e;
  endfunction

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    dec_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_decodes.push_back(predict_decode(first_word, second_word, instr_address));
      end
      if (out_valid && !out_stall) begin
        if (expected_decodes.size() == 0) begin
          $error("decode result arrived with no instruction outstanding");
          errors++;
        end else begin
          want = expected_decodes.pop_front();
          errors += field_differs("recognized", want.recognized, recognized);
          errors += field_differs("operation", want.operation, operation);
          errors += field_differs("addr_form", want.addr_form, addr_form);
          errors += field_differs("dest_reg", want.dest_reg, dest_reg);
          errors += field_differs("src_reg", want.src_reg, src_reg);
          errors += field_differs("src_is_pc", want.src_is_pc, src_is_pc);
          errors += field_differs("index_field", want.index_field, index_field);
          errors += field_differs("immediate", want.immediate, immediate);
          errors += field_differs("control_flow", want.control_flow, control_flow);
          errors += field_differs("delay_slot", want.delay_slot, delay_slot);
          errors += field_differs("invalid_in_delay_slot", want.invalid_in_delay_slot,
                                  invalid_in_delay_slot);
          errors += field_differs("pc_relative_delay", want.pc_relative_delay,
                                  pc_relative_delay);
        end
      end
    end
    fail_count <= errors;
    pending <= expected_decodes.size();
  end

endmodule

FILE: tb/tb_extended_instruction_decoder.sv
`timescale 1ns / 1ps

module tb_extended_instruction_decoder
  import eid_pkg::*;
();

  localparam int NUM_RANDOM   = 1725;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] first_word;
  logic [15:0] second_word;
  logic [31:0] instr_address;
  logic        out_valid;
  logic        out_stall;
  logic        recognized;
  logic [3:0]  operation;
  logic [2:0]  addr_form;
  logic [3:0]  dest_reg;
  logic [3:0]  src_reg;
  logic        src_is_pc;
  logic [15:0] index_field;
  logic [31:0] immediate;
  logic        control_flow;
  logic        delay_slot;
  logic        invalid_in_delay_slot;
  logic        pc_relative_delay;

  int fail_count;
  int pending;
  int results_taken = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  extended_instruction_decoder i_dut (
    .clk                   (clk),
    .rst                   (rst),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .first_word            (first_word),
    .second_word           (second_word),
    .instr_address         (instr_address),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .recognized            (recognized),
    .operation             (operation),
    .addr_form             (addr_form),
    .dest_reg              (dest_reg),
    .src_reg               (src_reg),
    .src_is_pc             (src_is_pc),
    .index_field           (index_field),
    .immediate             (immediate),
    .control_flow          (control_flow),
    .delay_slot            (delay_slot),
    .invalid_in_delay_slot (invalid_in_delay_slot),
    .pc_relative_delay     (pc_relative_delay)
  );

  eid_decode_checker i_checker (
    .clk                   (clk),
    .rst                   (rst),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .first_word            (first_word),
    .second_word           (second_word),
    .instr_address         (instr_address),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .recognized            (recognized),
    .operation             (operation),
    .addr_form             (addr_form),
    .dest_reg              (dest_reg),
    .src_reg               (src_reg),
    .src_is_pc             (src_is_pc),
    .index_field           (index_field),
    .immediate             (immediate),
    .control_flow          (control_flow),
    .delay_slot            (delay_slot),
    .invalid_in_delay_slot (invalid_in_delay_slot),
    .pc_relative_delay     (pc_relative_delay),
    .fail_count            (fail_count),
    .pending               (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("extended_instruction_decoder verification failed");
      $finish;
    end
  end

  // Offers one instruction after a random gap (none while quiet) and returns at the edge that takes it.
  task automatic send_instr(input logic [15:0] fw, input logic [15:0] sw,
                            input logic [31:0] pc);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    first_word <= fw;
    second_word <= sw;
    instr_address <= pc;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : result_sink
    int hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      // One long hold-off lets the pipeline fill and push back on the sender.
      if (results_taken == HOLD_AT) begin
        hold = HOLD_CYCLES;
      end else if (quiet) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 15);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  initial begin : stimulus
    logic [15:0] fw;
    logic [15:0] sw;
    logic [31:0] pc;
    logic [3:0]  grp;
    int          pick;
    rst <= 1'b1;
    in_valid <= 1'b0;
    first_word <= 16'd0;
    second_word <= 16'd0;
    instr_address <= 32'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_instr({PFX_MOVI, 8'h80}, 16'h0000, 32'h0000_0000);
    send_instr({PFX_MOVI, 8'h7F}, 16'hFFFF, 32'hFFFF_FFFF);
    send_instr({PFX_EXT, 8'hFF}, {GRP_IDX, 4'hF, 4'h0, 4'd4}, 32'h1234_5678);
    send_instr({PFX_EXT, 8'h5A}, {GRP_IDX, 4'h3, 4'hC, 4'd6}, 32'h0000_0100);
    send_instr({PFX_EXT, 8'h0F}, {GRP_IDX, 4'h0, 4'hF, 4'd12}, 32'h8000_0000);
    send_instr({PFX_EXT, 8'h80}, {GRP_STL, 4'h7, 4'h8, 4'hF}, 32'h0000_0002);
    send_instr({PFX_EXT, 8'h7F}, {GRP_ST, 4'h1, 4'h2, 4'd1}, 32'h0000_0004);
    send_instr({PFX_EXT, 8'h80}, {GRP_ST, 4'hE, 4'hD, 4'd4}, 32'h0000_0006);
    send_instr({PFX_EXT, 8'hFF}, {GRP_ST, 4'h2, 4'h3, 4'd6}, 32'h0000_0008);
    send_instr({PFX_EXT, 8'h01}, {GRP_LDL, 4'h4, 4'h5, 4'hF}, 32'h0000_000A);
    send_instr({PFX_EXT, 8'h3C}, {GRP_LD, 4'h6, 4'h7, 4'd5}, 32'h0000_000C);
    send_instr({PFX_EXT, 8'hA5}, {GRP_LD, 4'h8, 4'h9, 4'd6}, 32'h0000_000E);
    send_instr({PFX_EXT, 8'hFF}, {GRP_LD, 4'hA, 4'hB, 4'd7}, 32'h0000_0010);
    send_instr({PFX_EXT, 8'h80}, {GRP_LD, 4'hC, 4'hD, 4'd8}, 32'h0000_0012);
    send_instr({PFX_EXT, 8'h7F}, {GRP_LD, 4'hE, 4'hF, 4'd12}, 32'h0000_0014);
    send_instr({PFX_EXT, 8'hC3}, {GRP_LD, 4'h1, 4'h0, 4'd13}, 32'h0000_0016);
    send_instr({PFX_EXT, 8'h80}, {GRP_LD, 4'h0, 4'h1, 4'd14}, 32'h0000_0018);
    send_instr({PFX_EXT, 8'h55}, {GRP_LD, 4'h5, 4'h5, 4'd15}, 32'h0000_001A);
    send_instr({PFX_EXT, 8'h00}, {GRP_ADD, 4'hA, 8'h80}, 32'h0000_001C);
    send_instr({PFX_EXT, 8'hFF}, {GRP_MOV, 4'h5, 8'h7F}, 32'h0000_001E);
    // The aligned base wraps past the top of the address space here.
    send_instr({PFX_EXT, 8'hFF}, {GRP_MOVA, 4'hF, 8'hFF}, 32'hFFFF_FFFE);
    send_instr({PFX_EXT, 8'h00}, {GRP_BRA, 12'h800}, 32'h0000_0000);
    send_instr({PFX_EXT, 8'hFF}, {GRP_BSR, 12'h7FF}, 32'hFFFF_FFF0);
    send_instr({PFX_EXT, 8'h12}, 16'h3456, 32'h0000_0020);
    send_instr(16'hFFFF, 16'hE000, 32'h0000_0022);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      quiet = ((n / 150) % 4 == 2);
      pick = $urandom_range(0, 99);
      fw = 16'($urandom());
      sw = 16'($urandom());
      if (pick < 65) begin
        fw[15:8] = PFX_EXT;
      end else if (pick < 80) begin
        fw[15:8] = PFX_MOVI;
      end
      // Most extended items land in a defined group; the rest keep a random group code that can probe the empty slots.
      if (fw[15:8] == PFX_EXT && $urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 9))
          0: grp = GRP_IDX;
          1: grp = GRP_STL;
          2: grp = GRP_ST;
          3: grp = GRP_LDL;
          4: grp = GRP_LD;
          5: grp = GRP_ADD;
          6: grp = GRP_MOVA;
          7: grp = GRP_BRA;
          8: grp = GRP_BSR;
          default: grp = GRP_MOV;
        endcase
        sw[15:12] = grp;
      end
      pc = $urandom();
      if ($urandom_range(0, 9) == 0) begin
        pc[31:4] = ($urandom_range(0, 1) == 1) ? 28'hFFF_FFFF : 28'd0;
      end
      send_instr(fw, sw, pc);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("extended_instruction_decoder verification clean");
    end else begin
      $display("extended_instruction_decoder verification failed");
    end
    $finish;
  end

endmodule
